>>> rtl/assert_macros.svh
// Assertion helpers used by the swirl coordinate map core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/swirl_pkg.sv
`timescale 1ns / 1ps
package swirl_pkg;

  localparam int CoordBits    = 12;
  localparam int CordicStages = 16;
  localparam int MaxStages    = 24;

  localparam int OutW   = 18;
  localparam int AngW   = 18;
  localparam int ZW     = 22;   // Q.16 angle, with wrap headroom
  localparam int VW     = 34;   // Q.16 coordinates during rotation
  localparam int CfgW   = 18;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegAngle   = 2'd3;

  localparam logic signed [ZW-1:0] PiQ16     = 22'sd205887;
  localparam logic signed [ZW-1:0] TwoPiQ16  = 22'sd411775;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 22'sd102944;
  localparam logic signed [17:0]   InvGainQ16 = 18'sd39797;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0: v = 22'sd51472;  1: v = 22'sd30386;  2: v = 22'sd16055;
      3: v = 22'sd8150;   4: v = 22'sd4091;   5: v = 22'sd2047;
      6: v = 22'sd1024;   7: v = 22'sd512;    8: v = 22'sd256;
      9: v = 22'sd128;    10: v = 22'sd64;    11: v = 22'sd32;
      12: v = 22'sd16;    13: v = 22'sd8;     14: v = 22'sd4;
      15: v = 22'sd2;     16: v = 22'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/swirl_sqrt_cell.sv
`timescale 1ns / 1ps
// One restoring square-root step, one result bit per cell.
module swirl_sqrt_cell #(
  parameter int RW = 16,
  parameter int VWD = 34,
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic [VWD-1:0] v_in,
  input  logic [RW-1:0]  res_in,
  output logic [VWD-1:0] v_r,
  output logic [RW-1:0]  res_r
);
  logic [VWD-1:0] trial;
  logic [RW-1:0]  cand;
  always_comb begin
    cand = res_in | (RW'(1) << BIT);
    trial = VWD'(cand) * VWD'(cand);
  end
  always_ff @(posedge clk) begin
    v_r <= v_in;
    res_r <= (trial <= v_in) ? cand : res_in;
  end
endmodule

>>> rtl/swirl_cordic_cell.sv
`timescale 1ns / 1ps
module swirl_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic signed [swirl_pkg::VW-1:0]     x_in,
  input  logic signed [swirl_pkg::VW-1:0]     y_in,
  input  logic signed [swirl_pkg::ZW-1:0]     z_in,
  output logic signed [swirl_pkg::VW-1:0]     x_r,
  output logic signed [swirl_pkg::VW-1:0]     y_r,
  output logic signed [swirl_pkg::ZW-1:0]     z_r
);
  logic signed [swirl_pkg::VW-1:0] xs, ys;
  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
  end
  always_ff @(posedge clk) begin
    if (!z_in[swirl_pkg::ZW-1]) begin
      x_r <= x_in - ys;
      y_r <= y_in + xs;
      z_r <= z_in - swirl_pkg::atan_q16(STAGE);
    end else begin
      x_r <= x_in + ys;
      y_r <= y_in - xs;
      z_r <= z_in + swirl_pkg::atan_q16(STAGE);
    end
  end
endmodule

>>> rtl/swirl_coordinate_map_core.sv
`timescale 1ns / 1ps
// Swirl coordinate map.
// Input: a request is taken at each clock edge with start high; busy is tied
// low, so requests may follow back to back, one per clock.
// in_pixel_x/in_pixel_y give the destination pixel.
// Output: out_valid strobes for one cycle with out_source_x/out_source_y,
// signed Q13.4, saturated. Results come back in request order.
// Stages: (COORD_BITS+5) square-root cells + 13 divider cells
// + CORDIC_STAGES rotation cells + 8 other stages.
// Throughput: one request per clock; every cell hands its word onward each
// cycle. The receiver cannot stall; results must be taken when strobed.
// Configuration: cfg_we/cfg_index/cfg_data, written at once; change only
// while no request is in flight. Reset clears the config registers and valid
// chain, so no strobe appears until a request has run the full pipeline.
// The fraction (16r - dist)/(16r) comes from a restoring divider cell row.
`include "assert_macros.svh"
module swirl_coordinate_map_core #(
  parameter int COORD_BITS    = swirl_pkg::CoordBits,
  parameter int CORDIC_STAGES = swirl_pkg::CordicStages
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [COORD_BITS-1:0]              in_pixel_x,
  input  logic [COORD_BITS-1:0]              in_pixel_y,
  output logic                               out_valid,
  output logic signed [swirl_pkg::OutW-1:0]  out_source_x,
  output logic signed [swirl_pkg::OutW-1:0]  out_source_y,
  input  logic                               cfg_we,
  input  logic [swirl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [swirl_pkg::CfgW-1:0]         cfg_data
);
  localparam int DW   = COORD_BITS + 1;          // signed delta
  localparam int D2W  = 2*COORD_BITS + 1;        // dx^2+dy^2
  localparam int SVW  = D2W + 8;                 // d2*256
  localparam int SRW  = COORD_BITS + 5;          // sqrt result (dist4)
  localparam int R16W = COORD_BITS + 4;
  localparam int QW   = 13;                      // frac up to 4096
  localparam int NUMW = R16W + 12;
  localparam int VW   = swirl_pkg::VW;
  localparam int ZW   = swirl_pkg::ZW;
  localparam int OW   = swirl_pkg::OutW;
  localparam int WRAPS = 5;                      // most 2*pi turns in a delta

  // Stage counts
  localparam int SQ = SRW;     // sqrt cells
  localparam int DV = QW;      // divider cells
  localparam int PRE = 2;      // delta, d2 stages
  localparam int TOT = PRE + SQ + DV + 4 + CORDIC_STAGES + 2;

  logic [COORD_BITS-1:0] cx_r, cy_r, rad_r;
  logic signed [swirl_pkg::AngW-1:0] ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; rad_r <= '0; ang_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swirl_pkg::RegCenterX: cx_r  <= cfg_data[COORD_BITS-1:0];
        swirl_pkg::RegCenterY: cy_r  <= cfg_data[COORD_BITS-1:0];
        swirl_pkg::RegRadius:  rad_r <= cfg_data[COORD_BITS-1:0];
        swirl_pkg::RegAngle:   ang_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid chain
  logic [TOT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[TOT-2:0], start};
  end

  // pixel*16 as a Q13.4 coordinate, clipped at the output range
  function automatic logic signed [OW-1:0] pix16(input logic [COORD_BITS-1:0] p);
    logic [COORD_BITS+4:0] v;
    v = {1'b0, p, 4'b0};
    if (v > (COORD_BITS+5)'(131071)) return OW'(131071);
    return OW'(v);
  endfunction

  // stage 1: deltas
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [OW-1:0] px16_r, py16_r;
  always_ff @(posedge clk) begin
    dx_r <= $signed({1'b0, in_pixel_x}) - $signed({1'b0, cx_r});
    dy_r <= $signed({1'b0, in_pixel_y}) - $signed({1'b0, cy_r});
    px16_r <= pix16(in_pixel_x);
    py16_r <= pix16(in_pixel_y);
  end

  // stage 2: d2, inside test
  logic [D2W-1:0] d2_r;
  logic act2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic signed [OW-1:0] px2_r, py2_r;
  logic [D2W-1:0] d2_c;
  logic signed [2*DW-1:0] dxx_c, dyy_c;
  logic [2*COORD_BITS-1:0] r2_c;
  always_comb begin
    dxx_c = dx_r * dx_r;
    dyy_c = dy_r * dy_r;
    d2_c = D2W'($unsigned(dxx_c)) + D2W'($unsigned(dyy_c));
    r2_c = rad_r * rad_r;
  end
  always_ff @(posedge clk) begin
    d2_r <= d2_c;
    act2_r <= (d2_c != '0) && (d2_c < D2W'(r2_c));
    dx2_r <= dx_r; dy2_r <= dy_r; px2_r <= px16_r; py2_r <= py16_r;
  end

  // square-root cell row, MSB first
  logic [SVW-1:0] sv [SQ+1];
  logic [SRW-1:0] sr [SQ+1];
  logic signed [DW-1:0] sdx [SQ+1], sdy [SQ+1];
  logic signed [OW-1:0] spx [SQ+1], spy [SQ+1];
  logic sact [SQ+1];
  assign sv[0] = {d2_r, 8'b0};
  assign sr[0] = '0;
  assign sdx[0] = dx2_r; assign sdy[0] = dy2_r;
  assign spx[0] = px2_r; assign spy[0] = py2_r; assign sact[0] = act2_r;
  for (genvar g = 0; g < SQ; g++) begin : g_sq
    swirl_sqrt_cell #(.RW(SRW), .VWD(SVW), .BIT(SQ-1-g)) u_cell (
      .clk(clk), .v_in(sv[g]), .res_in(sr[g]), .v_r(sv[g+1]), .res_r(sr[g+1])
    );
    always_ff @(posedge clk) begin
      sdx[g+1] <= sdx[g]; sdy[g+1] <= sdy[g];
      spx[g+1] <= spx[g]; spy[g+1] <= spy[g]; sact[g+1] <= sact[g];
    end
  end

  // divider row: frac = (r16-dist4)*4096 / r16, restoring, one bit per cell
  logic [R16W-1:0] r16_c;
  assign r16_c = {rad_r, 4'b0};
  logic [NUMW-1:0] nrem [DV+1];
  logic [QW-1:0]   qq [DV+1];
  logic signed [DW-1:0] qdx [DV+1], qdy [DV+1];
  logic signed [OW-1:0] qpx [DV+1], qpy [DV+1];
  logic qact [DV+1];
  assign nrem[0] = sact[SQ] ? NUMW'(r16_c - R16W'(sr[SQ])) << 12 : '0;
  assign qq[0] = '0;
  assign qdx[0] = sdx[SQ]; assign qdy[0] = sdy[SQ];
  assign qpx[0] = spx[SQ]; assign qpy[0] = spy[SQ]; assign qact[0] = sact[SQ];
  for (genvar g = 0; g < DV; g++) begin : g_dv
    localparam int B = DV-1-g;
    logic [NUMW+QW-1:0] sub_c;
    assign sub_c = (NUMW+QW)'(r16_c) << B;
    always_ff @(posedge clk) begin
      if ((NUMW+QW)'(nrem[g]) >= sub_c) begin
        nrem[g+1] <= NUMW'((NUMW+QW)'(nrem[g]) - sub_c);
        qq[g+1] <= qq[g] | (QW'(1) << B);
      end else begin
        nrem[g+1] <= nrem[g];
        qq[g+1] <= qq[g];
      end
      qdx[g+1] <= qdx[g]; qdy[g+1] <= qdy[g];
      qpx[g+1] <= qpx[g]; qpy[g+1] <= qpy[g]; qact[g+1] <= qact[g];
    end
  end

  // angle: delta = floor(ang*frac/256), wrap, quadrant fold
  localparam int AngWP = swirl_pkg::AngW + QW + 1;
  logic signed [AngWP-1:0] prod_r;
  logic signed [ZW-1:0] z1_r, z2_r, z3_r;
  logic signed [DW-1:0] adx [3], ady [3];
  logic signed [OW-1:0] apx [4], apy [4];
  logic aact [4];
  logic signed [VW-1:0] x3_r, y3_r;
  logic signed [ZW-1:0] zoff_c;

  // thresholds grow with j, so the last one passed picks the turn count
  always_comb begin
    zoff_c = '0;
    for (int j = 1; j <= WRAPS; j++) begin
      if (z1_r > ZW'(swirl_pkg::PiQ16 + (j-1)*swirl_pkg::TwoPiQ16))
        zoff_c = ZW'(-j*swirl_pkg::TwoPiQ16);
      if (z1_r < ZW'(-swirl_pkg::PiQ16 - (j-1)*swirl_pkg::TwoPiQ16))
        zoff_c = ZW'(j*swirl_pkg::TwoPiQ16);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ang_r * $signed({1'b0, qq[DV]});
    adx[0] <= qdx[DV]; ady[0] <= qdy[DV];
    apx[0] <= qpx[DV]; apy[0] <= qpy[DV]; aact[0] <= qact[DV];
    z1_r <= ZW'(prod_r >>> 8);
    adx[1] <= adx[0]; ady[1] <= ady[0];
    apx[1] <= apx[0]; apy[1] <= apy[0]; aact[1] <= aact[0];
    z2_r <= z1_r + zoff_c;
    adx[2] <= adx[1]; ady[2] <= ady[1];
    apx[2] <= apx[1]; apy[2] <= apy[1]; aact[2] <= aact[1];
    if (z2_r > swirl_pkg::HalfPiQ16) begin
      z3_r <= z2_r - swirl_pkg::PiQ16;
      x3_r <= -(VW'(adx[2]) <<< 16); y3_r <= -(VW'(ady[2]) <<< 16);
    end else if (z2_r < -swirl_pkg::HalfPiQ16) begin
      z3_r <= z2_r + swirl_pkg::PiQ16;
      x3_r <= -(VW'(adx[2]) <<< 16); y3_r <= -(VW'(ady[2]) <<< 16);
    end else begin
      z3_r <= z2_r;
      x3_r <= VW'(adx[2]) <<< 16; y3_r <= VW'(ady[2]) <<< 16;
    end
    apx[3] <= apx[2]; apy[3] <= apy[2]; aact[3] <= aact[2];
  end

  // CORDIC cell row
  logic signed [VW-1:0] cxv [CORDIC_STAGES+1], cyv [CORDIC_STAGES+1];
  logic signed [ZW-1:0] czv [CORDIC_STAGES+1];
  logic signed [OW-1:0] cpx [CORDIC_STAGES+1], cpy [CORDIC_STAGES+1];
  logic cact [CORDIC_STAGES+1];
  assign cxv[0] = x3_r; assign cyv[0] = y3_r; assign czv[0] = z3_r;
  assign cpx[0] = apx[3]; assign cpy[0] = apy[3]; assign cact[0] = aact[3];
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cr
    swirl_cordic_cell #(.STAGE(g)) u_cell (
      .clk(clk), .x_in(cxv[g]), .y_in(cyv[g]), .z_in(czv[g]),
      .x_r(cxv[g+1]), .y_r(cyv[g+1]), .z_r(czv[g+1])
    );
    always_ff @(posedge clk) begin
      cpx[g+1] <= cpx[g]; cpy[g+1] <= cpy[g]; cact[g+1] <= cact[g];
    end
  end

  // gain, Q.4, add center, saturate
  localparam int MW = VW + 18;
  logic signed [MW-1:0] mx_r, my_r;
  logic signed [OW-1:0] fpx_r, fpy_r;
  logic fact_r;
  logic signed [MW-1:0] sx_c, sy_c;
  always_ff @(posedge clk) begin
    mx_r <= cxv[CORDIC_STAGES] * swirl_pkg::InvGainQ16;
    my_r <= cyv[CORDIC_STAGES] * swirl_pkg::InvGainQ16;
    fpx_r <= cpx[CORDIC_STAGES]; fpy_r <= cpy[CORDIC_STAGES];
    fact_r <= cact[CORDIC_STAGES];
  end
  function automatic logic signed [OW-1:0] sat(input logic signed [MW-1:0] v);
    if (v < MW'(-131072)) return OW'(-131072);
    if (v > MW'(131071)) return OW'(131071);
    return OW'(v);
  endfunction
  always_comb begin
    sx_c = $signed({1'b0, cx_r, 4'b0}) + ((mx_r + (MW'(1) <<< 27)) >>> 28);
    sy_c = $signed({1'b0, cy_r, 4'b0}) + ((my_r + (MW'(1) <<< 27)) >>> 28);
  end
  always_ff @(posedge clk) begin
    out_source_x <= fact_r ? sat(sx_c) : fpx_r;
    out_source_y <= fact_r ? sat(sy_c) : fpy_r;
  end
  assign out_valid = vld_r[TOT-1];

  `ASSERT_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy)
  `ASSERT_NEXT(a_valid_flow, clk, rst_n, start, vld_r[0])
  `ASSERT_NEXT(a_pass_inactive, clk, rst_n, vld_r[TOT-2] && !fact_r, out_source_x == $past(fpx_r))
endmodule
